FILE: design/bcis_pkg.sv
// Package for the byte CPU step block: command codes, controller states,
// and the command and status structs between controller and datapath. No dependencies.
package bcis_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_OPER,
        ST_EXEC,
        ST_DONE
    } t_state;

    // memory address source
    typedef enum logic [1:0] {
        AS_ADDR = 2'd0,
        AS_RP   = 2'd1,
        AS_RN   = 2'd2,
        AS_RX   = 2'd3
    } t_asel;

    typedef struct packed {
        logic  load_in;    // capture the input word
        logic  mem_rd;     // launch a memory read
        t_asel asel;
        logic  mem_wr_ext; // write wdata at addr
        logic  latch_op;   // opcode register takes read data
        logic  exec;       // execute with operand in read data
        logic  rd_capture; // rdata takes read data
        logic  clr_rdata;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic need_mem;    // instruction reads memory
        logic mem_addr_rn; // operand address R(N)
        logic mem_addr_rp; // operand address R(P)
    } t_sts;

    localparam logic [15:0] HI_MASK = 16'hff00;
    localparam logic [15:0] LO_MASK = 16'h00ff;

endpackage

FILE: design/byte_cpu_instruction_step.sv
// Top level of the byte CPU step block: controller plus datapath.
// Depends on bcis_pkg, bcis_ctrl, bcis_dp.
//
//   channel | handshake               | fields
//   --------+-------------------------+-----------------------------------------
//   in      | i_valid / o_in_stall    | i_cmd i_addr i_wdata i_ext_flags
//   out     | o_valid / i_out_stall   | o_acc_value .. o_prog_counter o_rdata
//
// A memory write or read passes through fetch and execute from accept to
// result; an instruction passes through opcode fetch, decode, an operand
// read when it needs one, and execute, set by the single memory port. The
// idle state follows each result before the next word is taken. One word in flight at
// a time; the result holds while the output stalls. Reset clears registers
// and flags; memory stays undefined until written, so no clearing pass runs.
module byte_cpu_instruction_step
    import bcis_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [3:0]  i_ext_flags,
    output logic        o_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_acc_value,
    output logic        o_carry_flag,
    output logic        o_q_out,
    output logic        o_int_enable,
    output logic [3:0]  o_prog_sel,
    output logic [3:0]  o_data_sel,
    output logic [15:0] o_prog_counter,
    output logic [7:0]  o_rdata
);
    t_ctl w_ctl;
    t_sts w_sts;

    // sequence each word through fetch, decode, operand and execute
    bcis_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_in_stall, .o_valid, .i_out_stall,
        .i_sts(w_sts), .o_ctl(w_ctl)
    );

    // hold all architectural state and the memory
    bcis_dp #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .o_sts(w_sts),
        .i_cmd, .i_addr, .i_wdata, .i_ext_flags,
        .o_acc_value, .o_carry_flag, .o_q_out, .o_int_enable,
        .o_prog_sel, .o_data_sel, .o_prog_counter, .o_rdata
    );
endmodule

FILE: design/bcis_ctrl.sv
// Controller state machine of the byte CPU step block.
// Depends on bcis_pkg.
module bcis_ctrl
    import bcis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_in_stall,
    output logic o_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_FETCH;
            ST_FETCH:  n_state = (i_sts.cmd == CMD_EXEC) ? ST_DECODE : ST_EXEC;
            ST_DECODE: n_state = i_sts.need_mem ? ST_OPER : ST_EXEC;
            ST_OPER:   n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_DONE;
            ST_DONE:   if (!i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.asel = AS_ADDR;
        o_in_stall = (r_state != ST_IDLE);
        o_valid    = (r_state == ST_DONE);
        case (r_state)
            ST_IDLE: o_ctl.load_in = i_valid;
            ST_FETCH: begin
                case (i_sts.cmd)
                    CMD_EXEC: begin
                        o_ctl.mem_rd = 1'b1;
                        o_ctl.asel   = AS_RP;
                    end
                    CMD_READ:  o_ctl.mem_rd = 1'b1;
                    CMD_WRITE: o_ctl.mem_wr_ext = 1'b1;
                    default:   o_ctl.clr_rdata = 1'b1;
                endcase
            end
            ST_DECODE: begin
                o_ctl.latch_op = 1'b1;
                o_ctl.mem_rd   = i_sts.need_mem;
                o_ctl.asel     = i_sts.mem_addr_rn ? AS_RN :
                                 i_sts.mem_addr_rp ? AS_RP : AS_RX;
            end
            ST_EXEC: begin
                o_ctl.exec       = (i_sts.cmd == CMD_EXEC);
                o_ctl.rd_capture = (i_sts.cmd == CMD_READ);
                o_ctl.clr_rdata  = (i_sts.cmd != CMD_READ);
            end
            default: ;
        endcase
    end
endmodule

FILE: design/bcis_dp.sv
// Datapath of the byte CPU step block: memory, register file, D, DF, flags.
// Depends on bcis_pkg.
module bcis_dp
    import bcis_pkg::*;
#(
    parameter int MEM_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [3:0]  i_ext_flags,
    output logic [7:0]  o_acc_value,
    output logic        o_carry_flag,
    output logic        o_q_out,
    output logic        o_int_enable,
    output logic [3:0]  o_prog_sel,
    output logic [3:0]  o_data_sel,
    output logic [15:0] o_prog_counter,
    output logic [7:0]  o_rdata
);
    localparam int AW = $clog2(MEM_DEPTH);

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_mdata;

    logic [15:0] r_regs [16];
    logic [15:0] n_regs [16];
    logic [3:0]  r_p, n_p, r_x, n_x;
    logic [7:0]  r_d, n_d, r_t, n_t;
    logic        r_df, n_df, r_q, n_q, r_ie, n_ie;

    t_cmd        r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata, r_op, r_rdata;
    logic [3:0]  r_flags;

    logic [15:0] w_addr;
    logic [15:0] w_pc1;
    logic [3:0]  w_n, w_hi;
    logic        w_wr;
    logic [15:0] w_waddr;
    logic [7:0]  w_wbyte;

    assign w_hi = r_op[7:4];
    assign w_n  = r_op[3:0];

    // R(P) as it stands once the opcode fetch has advanced it
    assign w_pc1 = r_regs[r_p] + 16'd1;

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_flags <= i_ext_flags;
        end
        if (i_ctl.latch_op) r_op <= r_mdata;
    end

    // decode of the opcode still in read data during the decode cycle
    logic [3:0] w_dh, w_dn;
    assign w_dh = r_mdata[7:4];
    assign w_dn = r_mdata[3:0];
    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.mem_addr_rn = (w_dh == 4'h0) || (w_dh == 4'h4);
        o_sts.mem_addr_rp = (w_dh == 4'h3) ||
                            ((w_dh == 4'h7) && (w_dn == 4'hc || w_dn == 4'hd ||
                                                w_dn == 4'hf));
        o_sts.need_mem    = o_sts.mem_addr_rn || (w_dh == 4'h3) || (w_dh == 4'h7);
    end

    // operand reads see the program counter already stepped past the opcode
    always_comb begin
        case (i_ctl.asel)
            AS_RP:   w_addr = i_ctl.latch_op ? w_pc1 : r_regs[r_p];
            AS_RN:   w_addr = (w_dn == r_p) ? w_pc1 : r_regs[w_dn];
            AS_RX:   w_addr = (r_x == r_p) ? w_pc1 : r_regs[r_x];
            default: w_addr = r_addr;
        endcase
    end

    // single port memory
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_waddr[AW-1:0]] <= w_wbyte;
        if (i_ctl.mem_rd) r_mdata <= r_mem[w_addr[AW-1:0]];
    end

    // execute: PC was not yet advanced; model fetch then step
    logic [15:0] w_rx;
    logic [8:0]  w_sum;
    logic [7:0]  w_a, w_b;
    logic        w_cin, w_add, w_cond;

    always_comb begin
        for (int i = 0; i < 16; i++) n_regs[i] = r_regs[i];
        n_p = r_p; n_x = r_x; n_d = r_d; n_t = r_t;
        n_df = r_df; n_q = r_q; n_ie = r_ie;
        w_wr = 1'b0; w_waddr = r_addr; w_wbyte = r_wdata;
        w_a = r_mdata; w_b = r_d; w_cin = r_df; w_add = 1'b0; w_cond = 1'b0;
        w_rx  = r_regs[r_x];
        w_sum = '0;
        if (i_ctl.mem_wr_ext) begin
            w_wr = 1'b1;
        end
        if (i_ctl.exec) begin
            n_regs[r_p] = w_pc1;
            case (w_hi)
                4'h0: if (w_n != 4'h0) n_d = r_mdata;
                4'h1: n_regs[w_n] = r_regs[w_n] + ((w_n == r_p) ? 16'd2 : 16'd1);
                4'h2: n_regs[w_n] = (w_n == r_p) ? r_regs[w_n] : r_regs[w_n] - 16'd1;
                4'h3: begin
                    case (w_n[2:0])
                        3'd0: w_cond = 1'b1;
                        3'd1: w_cond = r_q;
                        3'd2: w_cond = (r_d == 8'd0);
                        3'd3: w_cond = r_df;
                        default: w_cond = r_flags[w_n[1:0]];
                    endcase
                    w_cond = w_cond ^ w_n[3];
                    n_regs[r_p] = w_cond ? ((w_pc1 & HI_MASK) | {8'd0, r_mdata})
                                         : w_pc1 + 16'd1;
                end
                4'h4: begin
                    n_d = r_mdata;
                    n_regs[w_n] = ((w_n == r_p) ? w_pc1 : r_regs[w_n]) + 16'd1;
                end
                4'h5: begin
                    w_wr = 1'b1; w_waddr = (w_n == r_p) ? w_pc1 : r_regs[w_n];
                    w_wbyte = r_d;
                end
                4'h6: if (w_n == 4'h0)
                    n_regs[r_x] = ((r_x == r_p) ? w_pc1 : w_rx) + 16'd1;
                4'h7: begin
                    case (w_n)
                        4'h0, 4'h1: begin
                            n_regs[r_x] = ((r_x == r_p) ? w_pc1 : w_rx) + 16'd1;
                            n_x = r_mdata[7:4]; n_p = r_mdata[3:0];
                            n_ie = ~w_n[0];
                        end
                        4'h2: begin
                            n_d = r_mdata;
                            n_regs[r_x] = ((r_x == r_p) ? w_pc1 : w_rx) + 16'd1;
                        end
                        4'h3: begin
                            w_wr = 1'b1; w_wbyte = r_d;
                            w_waddr = (r_x == r_p) ? w_pc1 : w_rx;
                            n_regs[r_x] = w_waddr - 16'd1;
                        end
                        4'h4, 4'hc: w_add = 1'b1;
                        4'h5, 4'hd: begin w_add = 1'b1; w_b = ~r_d; end
                        4'h7, 4'hf: begin w_add = 1'b1; w_a = r_d; w_b = ~r_mdata; end
                        4'h6: begin n_df = r_d[0]; n_d = {r_df, r_d[7:1]}; end
                        4'he: begin n_df = r_d[7]; n_d = {r_d[6:0], r_df}; end
                        4'h8: begin
                            w_wr = 1'b1; w_wbyte = r_t;
                            w_waddr = (r_x == r_p) ? w_pc1 : w_rx;
                        end
                        4'h9: begin
                            n_t = {r_x, r_p}; w_wr = 1'b1; w_wbyte = {r_x, r_p};
                            w_waddr = (r_p == 4'd2) ? w_pc1 : r_regs[2];
                            n_regs[2] = w_waddr - 16'd1;
                            n_x = r_p;
                        end
                        4'ha: n_q = 1'b0;
                        default: n_q = 1'b1;
                    endcase
                    if (w_n == 4'hc || w_n == 4'hd || w_n == 4'hf)
                        n_regs[r_p] = w_pc1 + 16'd1;
                    w_sum = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_cin};
                    if (w_add) begin n_d = w_sum[7:0]; n_df = w_sum[8]; end
                end
                4'h8: n_d = ((w_n == r_p) ? w_pc1[7:0] : r_regs[w_n][7:0]);
                4'h9: n_d = ((w_n == r_p) ? w_pc1[15:8] : r_regs[w_n][15:8]);
                4'ha: n_regs[w_n] = (((w_n == r_p) ? w_pc1 : r_regs[w_n]) & HI_MASK)
                                    | {8'd0, r_d};
                4'hb: n_regs[w_n] = (((w_n == r_p) ? w_pc1 : r_regs[w_n]) & LO_MASK)
                                    | {r_d, 8'd0};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_regs[i] <= '0;
            r_p <= '0; r_x <= '0; r_d <= '0; r_t <= '0;
            r_df <= 1'b0; r_q <= 1'b0; r_ie <= 1'b0;
        end else begin
            for (int i = 0; i < 16; i++) r_regs[i] <= n_regs[i];
            r_p <= n_p; r_x <= n_x; r_d <= n_d; r_t <= n_t;
            r_df <= n_df; r_q <= n_q; r_ie <= n_ie;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_capture) r_rdata <= r_mdata;
        else if (i_ctl.clr_rdata) r_rdata <= '0;
    end

    assign o_acc_value    = r_d;
    assign o_carry_flag   = r_df;
    assign o_q_out        = r_q;
    assign o_int_enable   = r_ie;
    assign o_prog_sel     = r_p;
    assign o_data_sel     = r_x;
    assign o_prog_counter = r_regs[r_p];
    assign o_rdata        = r_rdata;
endmodule

FILE: design/bcis_chk.sv
// Port checker for the byte CPU step block, bound to the top level.
// Depends on nothing beyond the top level's ports.
module bcis_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_in_stall,
    input logic        o_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_prog_sel,
    input logic [7:0]  o_acc_value
);
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_in_stall) else $error("input open while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_out_stall |=> o_valid && $stable(o_acc_value)
        && $stable(o_prog_sel)) else $error("stalled result changed");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_in_stall |=> !o_valid ##1 !o_valid)
        else $error("result too early");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind byte_cpu_instruction_step bcis_chk u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_in_stall, .o_valid, .i_out_stall,
    .o_prog_sel, .o_acc_value
);

FILE: dv/tb_byte_cpu_instruction_step.sv
// Testbench for byte_cpu_instruction_step: a predictor of the CPU state runs while the
// stimulus is built, and a valid/stall driver and monitor check every result word.
// Depends on bcis_pkg and the block's RTL.
module tb_byte_cpu_instruction_step;
    import bcis_pkg::*;

    // Opcode groups (high nibble) and the 7N sub-operations
    localparam logic [3:0] GRP_LDN = 4'h0, GRP_INC = 4'h1, GRP_DEC = 4'h2, GRP_BR = 4'h3;
    localparam logic [3:0] GRP_LDA = 4'h4, GRP_STR = 4'h5, GRP_IRX = 4'h6, GRP_SEVEN = 4'h7;
    localparam logic [3:0] GRP_GLO = 4'h8, GRP_GHI = 4'h9, GRP_PLO = 4'ha, GRP_PHI = 4'hb;
    localparam logic [3:0] SUB_RET = 4'h0, SUB_DIS = 4'h1, SUB_LDXA = 4'h2, SUB_STXD = 4'h3;
    localparam logic [3:0] SUB_ADC = 4'h4, SUB_SDB = 4'h5, SUB_SHRC = 4'h6, SUB_SMB = 4'h7;
    localparam logic [3:0] SUB_SAV = 4'h8, SUB_MARK = 4'h9, SUB_REQ = 4'ha, SUB_SEQ = 4'hb;
    localparam logic [3:0] SUB_ADCI = 4'hc, SUB_SDBI = 4'hd, SUB_SHLC = 4'he, SUB_SMBI = 4'hf;
    localparam logic [7:0] OP_IDLE = 8'h00, OP_OUT = 8'h61, OP_UPPER = 8'hc4, OP_TOP = 8'hff;
    localparam logic [7:0] OP_BR = 8'h30, OP_BN1 = 8'h3c, OP_B4 = 8'h37, OP_BZ = 8'h32;
    localparam logic [7:0] OP_RET = 8'h70, OP_DIS = 8'h71, OP_SMB = 8'h77, OP_SMBI = 8'h7f;
    localparam logic [7:0] OP_SEQ = 8'h7b, OP_REQ = 8'h7a, OP_GLO = 8'h81, OP_GHI = 8'h91;
    localparam logic [7:0] OP_PHI = 8'hb1, OP_PLO = 8'ha1, OP_MARK = 8'h79, OP_SHLC = 8'h7e;
    localparam int N_ITEMS = 550;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [3:0]  flags;
        logic        drain_first;   // hold this word until nothing is in flight
    } t_word;

    typedef struct packed {
        logic [7:0]  acc;
        logic        df;
        logic        q;
        logic        ie;
        logic [3:0]  p;
        logic [3:0]  x;
        logic [15:0] pc;
        logic [7:0]  rdata;
    } t_state_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_addr = '0;
    logic [7:0]  i_wdata = '0;
    logic [3:0]  i_ext_flags = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_valid, o_carry_flag, o_q_out, o_int_enable;
    logic [7:0]  o_acc_value, o_rdata;
    logic [3:0]  o_prog_sel, o_data_sel;
    logic [15:0] o_prog_counter;

    byte_cpu_instruction_step DUT (.*);

    always #1 i_clk = ~i_clk;

    // CPU state mirror: registers, selectors, flags, and the written part of memory
    logic [15:0] reg_file [16];
    logic [3:0]  p_sel, x_sel;
    logic [7:0]  d_acc, t_xp;
    logic        df_bit, q_bit, ie_bit;
    logic [7:0]  mem_img [logic [15:0]];
    logic [15:0] written_addrs [$];

    t_word       pending_words [$];
    t_state_word expected_states [$];

    int unsigned n_accepted = 0, n_returned = 0, n_mismatch = 0, idle_cycles = 0;

    function automatic logic [7:0] mem_peek(logic [15:0] a);
        return mem_img.exists(a) ? mem_img[a] : 8'h00;
    endfunction

    function automatic void mem_poke(logic [15:0] a, logic [7:0] v);
        if (!mem_img.exists(a)) written_addrs.push_back(a);
        mem_img[a] = v;
    endfunction

    // D = a + b + cin, DF = carry out; subtracts pass ~b with DF as no-borrow
    function automatic void add_d(logic [7:0] a, logic [7:0] b, logic cin);
        {df_bit, d_acc} = {1'b0, a} + {1'b0, b} + {8'h00, cin};
    endfunction

    function automatic void exec_seven(logic [3:0] n);
        logic [15:0] rx;
        logic [7:0]  m;
        logic        old;
        rx = reg_file[x_sel];
        case (n)
            SUB_RET, SUB_DIS: begin
                m = mem_peek(rx);
                reg_file[x_sel] = rx + 16'd1;
                x_sel = m[7:4];
                p_sel = m[3:0];
                ie_bit = (n == SUB_RET);
            end
            SUB_LDXA: begin
                d_acc = mem_peek(rx);
                reg_file[x_sel] = rx + 16'd1;
            end
            SUB_STXD: begin
                mem_poke(rx, d_acc);
                reg_file[x_sel] = rx - 16'd1;
            end
            SUB_ADC: add_d(mem_peek(rx), d_acc, df_bit);
            SUB_SDB: add_d(mem_peek(rx), ~d_acc, df_bit);
            SUB_SHRC: begin
                old = df_bit;
                df_bit = d_acc[0];
                d_acc = {old, d_acc[7:1]};
            end
            SUB_SMB: add_d(d_acc, ~mem_peek(rx), df_bit);
            SUB_SAV: mem_poke(rx, t_xp);
            SUB_MARK: begin
                t_xp = {x_sel, p_sel};
                mem_poke(reg_file[2], t_xp);
                x_sel = p_sel;
                reg_file[2] = reg_file[2] - 16'd1;
            end
            SUB_REQ: q_bit = 1'b0;
            SUB_SEQ: q_bit = 1'b1;
            SUB_SHLC: begin
                old = df_bit;
                df_bit = d_acc[7];
                d_acc = {d_acc[6:0], old};
            end
            default: begin
                // immediate forms take their operand at R(P) and step past it
                m = mem_peek(reg_file[p_sel]);
                reg_file[p_sel] = reg_file[p_sel] + 16'd1;
                if (n == SUB_ADCI) add_d(m, d_acc, df_bit);
                else if (n == SUB_SDBI) add_d(m, ~d_acc, df_bit);
                else add_d(d_acc, ~m, df_bit);
            end
        endcase
    endfunction

    function automatic void exec_instruction(logic [3:0] flags);
        logic [7:0]  op;
        logic [3:0]  n;
        logic [15:0] pc;
        logic        cond;
        op = mem_peek(reg_file[p_sel]);
        n = op[3:0];
        reg_file[p_sel] = reg_file[p_sel] + 16'd1;
        case (op[7:4])
            GRP_LDN: if (n != 4'h0) d_acc = mem_peek(reg_file[n]);
            GRP_INC: reg_file[n] = reg_file[n] + 16'd1;
            GRP_DEC: reg_file[n] = reg_file[n] - 16'd1;
            GRP_BR: begin
                pc = reg_file[p_sel];
                case (n[2:0])
                    3'd0: cond = 1'b1;
                    3'd1: cond = q_bit;
                    3'd2: cond = (d_acc == 8'h00);
                    3'd3: cond = df_bit;
                    default: cond = flags[n[1:0]];
                endcase
                if (n[3]) cond = ~cond;
                reg_file[p_sel] = cond ? {pc[15:8], mem_peek(pc)} : pc + 16'd1;
            end
            GRP_LDA: begin
                d_acc = mem_peek(reg_file[n]);
                reg_file[n] = reg_file[n] + 16'd1;
            end
            GRP_STR: mem_poke(reg_file[n], d_acc);
            GRP_IRX: if (n == 4'h0) reg_file[x_sel] = reg_file[x_sel] + 16'd1;
            GRP_SEVEN: exec_seven(n);
            GRP_GLO: d_acc = reg_file[n][7:0];
            GRP_GHI: d_acc = reg_file[n][15:8];
            GRP_PLO: reg_file[n][7:0] = d_acc;
            GRP_PHI: reg_file[n][15:8] = d_acc;
            default: ;
        endcase
    endfunction

    // Advance the mirror by one word and queue the word with its expected state
    task automatic push_word(t_cmd cmd, logic [15:0] addr, logic [7:0] wdata,
                             logic [3:0] flags, logic drain_first = 1'b0);
        t_word       w;
        t_state_word s;
        s.rdata = 8'h00;
        case (cmd)
            CMD_WRITE: mem_poke(addr, wdata);
            CMD_EXEC:  exec_instruction(flags);
            CMD_READ:  s.rdata = mem_peek(addr);
            default: ;
        endcase
        s.acc = d_acc;
        s.df = df_bit;
        s.q = q_bit;
        s.ie = ie_bit;
        s.p = p_sel;
        s.x = x_sel;
        s.pc = reg_file[p_sel];
        w = '{cmd: cmd, addr: addr, wdata: wdata, flags: flags, drain_first: drain_first};
        pending_words.push_back(w);
        expected_states.push_back(s);
    endtask

    task automatic fill_if_blank(logic [15:0] a);
        if (!mem_img.exists(a)) push_word(CMD_WRITE, a, 8'($urandom), 4'($urandom));
    endtask

    // Execute the byte at R(P), first seeding every byte the opcode will read
    task automatic run_op(logic [7:0] op, logic plant, logic [3:0] flags);
        logic [15:0] pc1, rn, rx;
        logic [3:0]  n;
        if (plant) push_word(CMD_WRITE, reg_file[p_sel], op, 4'($urandom));
        else fill_if_blank(reg_file[p_sel]);
        op = mem_peek(reg_file[p_sel]);
        n = op[3:0];
        pc1 = reg_file[p_sel] + 16'd1;
        rn = (n == p_sel) ? pc1 : reg_file[n];
        rx = (x_sel == p_sel) ? pc1 : reg_file[x_sel];
        case (op[7:4])
            GRP_LDN: if (n != 4'h0) fill_if_blank(rn);
            GRP_LDA: fill_if_blank(rn);
            GRP_BR: fill_if_blank(pc1);
            GRP_SEVEN: begin
                if (n inside {SUB_RET, SUB_DIS, SUB_LDXA, SUB_ADC, SUB_SDB, SUB_SMB})
                    fill_if_blank(rx);
                else if (n inside {SUB_ADCI, SUB_SDBI, SUB_SMBI})
                    fill_if_blank(pc1);
            end
            default: ;
        endcase
        push_word(CMD_EXEC, 16'h0000, 8'($urandom), flags);
    endtask

    initial begin
        logic [7:0] directed_ops [$];
        int unsigned pick;
        for (int k = 0; k < 16; k++) reg_file[k] = 16'h0000;
        p_sel = '0;
        x_sel = '0;
        d_acc = '0;
        t_xp = '0;
        df_bit = 1'b0;
        q_bit = 1'b0;
        ie_bit = 1'b0;

        // Directed: address and data extremes, unused command, then every special opcode
        push_word(CMD_WRITE, 16'hffff, 8'hff, 4'hf);
        push_word(CMD_WRITE, 16'h0000, 8'h00, 4'h0);
        push_word(CMD_READ, 16'hffff, 8'h00, 4'h0, 1'b1);
        push_word(CMD_NONE, 16'hffff, 8'hff, 4'hf);
        directed_ops = '{OP_IDLE, OP_OUT, OP_UPPER, OP_TOP, OP_SEQ, OP_BN1, OP_B4, OP_SMB,
                         OP_SMBI, OP_GHI, OP_PHI, OP_GLO, OP_PLO, OP_SHLC, OP_BZ, OP_MARK,
                         OP_RET, OP_DIS, OP_REQ, OP_BR};
        foreach (directed_ops[k]) run_op(directed_ops[k], 1'b1, 4'($urandom));

        // Random: mostly planted instructions, some left to run on, plus memory traffic
        while (pending_words.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) run_op(8'($urandom), 1'b1, 4'($urandom));
            else if (pick < 70) run_op(8'h00, 1'b0, 4'($urandom));
            else if (pick < 82)
                push_word(CMD_WRITE, 16'($urandom), 8'($urandom), 4'($urandom));
            else if (pick < 95)
                push_word(CMD_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                          8'($urandom), 4'($urandom), pick == 94);
            else push_word(CMD_NONE, 16'($urandom), 8'($urandom), 4'($urandom));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait out the stimulus and every result, then the block's latency
        do @(posedge i_clk); while (pending_words.size() != 0 || i_valid
                                    || expected_states.size() != 0);
        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0 && expected_states.size() == 0 && !o_valid) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Driver: bursts of words separated by random gaps; payload holds while stalled
    int unsigned burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        logic in_done, out_done;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            in_done = i_valid && !o_in_stall;
            out_done = o_valid && !i_out_stall;
            if (in_done) n_accepted <= n_accepted + 1;
            if (!i_valid || in_done) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0 && (!pending_words[0].drain_first
                        || n_accepted + in_done == n_returned + out_done)) begin
                    i_valid <= 1'b1;
                    i_cmd <= pending_words[0].cmd;
                    i_addr <= pending_words[0].addr;
                    i_wdata <= pending_words[0].wdata;
                    i_ext_flags <= pending_words[0].flags;
                    void'(pending_words.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall in phases of varying density, compare each word with the oldest expectation
    int unsigned stall_phase = 0;
    always @(posedge i_clk) begin
        t_state_word got, want;
        stall_phase <= stall_phase + 1;
        case (stall_phase[7:6])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= $urandom_range(0, 1);
        endcase
        if (i_rst_n && o_valid && !i_out_stall) begin
            n_returned <= n_returned + 1;
            got = '{acc: o_acc_value, df: o_carry_flag, q: o_q_out, ie: o_int_enable,
                    p: o_prog_sel, x: o_data_sel, pc: o_prog_counter, rdata: o_rdata};
            if (expected_states.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10) $display("unexpected result word %p", got);
            end else begin
                want = expected_states.pop_front();
                if (got !== want) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("result %0d: expected %p, got %p", n_returned, want, got);
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_in_stall) || (o_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
design/bcis_pkg.sv
design/bcis_ctrl.sv
design/bcis_dp.sv
design/byte_cpu_instruction_step.sv
design/bcis_chk.sv
dv/tb_byte_cpu_instruction_step.sv
